### hw/rtl/mps_pkg.sv
// Shared types and codes for the maxrects placement score block.
// No dependencies; used by maxrects_placement_score.
`timescale 1ns / 1ps
`default_nettype none

package mps_pkg;

   // Sequencer states
   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_SCAN,
      S_DRAIN,
      S_BORDER,
      S_RESP
   } state_type;

   // Action codes of an input word
   localparam logic [1:0] ACT_CLEAR  = 2'd0;
   localparam logic [1:0] ACT_APPEND = 2'd1;
   localparam logic [1:0] ACT_SCORE  = 2'd2;

   // Status codes of a result word
   localparam logic [1:0] ST_DONE     = 2'd0;
   localparam logic [1:0] ST_FULL     = 2'd1;
   localparam logic [1:0] ST_SCORE_OK = 2'd2;

   // Scoring modes
   localparam logic [2:0] MODE_NONE       = 3'd0;
   localparam logic [2:0] MODE_TOP_LEFT   = 3'd1;
   localparam logic [2:0] MODE_AREA       = 3'd2;
   localparam logic [2:0] MODE_SHORT_SIDE = 3'd3;
   localparam logic [2:0] MODE_LONG_SIDE  = 3'd4;
   localparam logic [2:0] MODE_MIN_WIDTH  = 3'd5;
   localparam logic [2:0] MODE_MIN_HEIGHT = 3'd6;

   // Register map
   localparam int          CSR_ADDR_W     = 1;
   localparam int          CSR_DATA_W     = 14;
   localparam int          MODE_W         = 3;
   localparam int          BIN_W          = 14;
   localparam logic [0:0]  REG_SCORE_MODE = 1'd0;
   localparam logic [0:0]  REG_BIN_WIDTH  = 1'd1;

   // Score format and bonuses
   localparam int SCORE_W        = 29;
   localparam int SCORE_MAX      = 268435455;
   localparam int SCORE_MIN      = -268435456;
   localparam int NEIGHBOR_BONUS = 5;
   localparam int BORDER_BONUS   = 1;

endpackage

`default_nettype wire

### hw/rtl/maxrects_placement_score.sv
// Placement score for rectangle bin packing: table of placed rectangles
// plus a sequenced scoring datapath. Depends on mps_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Ports                                  Handshake
// -------   -------------------------------------  ------------------------
// request   req_action, req_rect_*, req_image_*,   start high, busy low
//           req_left_in, req_right_in
// result    rsp_score, rsp_left_found,             rsp_valid, one cycle,
//           rsp_right_found, rsp_status            no back-pressure
// config    csr_addr, csr_wdata                    csr_we
//
// Clear, append, unused action and all modes but top-left: the result word
// is strobed after the exec and response states. Top-left scoring walks the
// table through the single read port of the rectangle memory, one entry a
// cycle, then passes the drain and border states, or goes straight to the
// border state with an empty table. busy stays high until the result cycle,
// in which a new word may already be accepted. Reset (synchronous) empties
// the table and clears the registers; no clearing pass is needed.

module maxrects_placement_score #(
   parameter int MAX_RECTS  = 256,
   parameter int COORD_BITS = 14
) (
   input  wire                                  clock,
   input  wire                                  reset,
   // request
   input  wire                                  start,
   output logic                                 busy,
   input  wire  [1:0]                           req_action,
   input  wire  [COORD_BITS-1:0]                req_rect_x,
   input  wire  [COORD_BITS-1:0]                req_rect_y,
   input  wire  [COORD_BITS-1:0]                req_rect_w,
   input  wire  [COORD_BITS-1:0]                req_rect_h,
   input  wire  [COORD_BITS-1:0]                req_image_w,
   input  wire  [COORD_BITS-1:0]                req_image_h,
   input  wire                                  req_left_in,
   input  wire                                  req_right_in,
   // result
   output logic                                 rsp_valid,
   output logic signed [mps_pkg::SCORE_W-1:0]   rsp_score,
   output logic                                 rsp_left_found,
   output logic                                 rsp_right_found,
   output logic [1:0]                           rsp_status,
   // configuration
   input  wire                                  csr_we,
   input  wire  [mps_pkg::CSR_ADDR_W-1:0]       csr_addr,
   input  wire  [mps_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam int CW    = COORD_BITS;
   localparam int CNT_W = $clog2(MAX_RECTS + 1);
   localparam int AW    = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
   localparam int ENT_W = 4 * CW;
   localparam int ACC_W = 2 * CW + CNT_W + 5;
   localparam int SAT_W = ((ACC_W > mps_pkg::SCORE_W) ? ACC_W : mps_pkg::SCORE_W) + 1;
   localparam int BW    = (CW < mps_pkg::BIN_W) ? CW : mps_pkg::BIN_W;

   // control registers
   mps_pkg::state_type               state_ff, state_in;
   logic [CNT_W-1:0]                 count_ff, count_in;
   logic [CNT_W-1:0]                 idx_ff, idx_in;
   logic                             rd_vld_ff;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [mps_pkg::MODE_W-1:0]       mode_ff;
   logic [mps_pkg::BIN_W-1:0]        bin_width_ff;

   // payload registers
   logic [1:0]                       act_ff, act_in;
   logic [CW-1:0]                    x_ff, x_in, y_ff, y_in, w_ff, w_in, h_ff, h_in;
   logic [CW-1:0]                    iw_ff, iw_in, ih_ff, ih_in;
   logic                             lf_ff, lf_in, rf_ff, rf_in;
   logic signed [ACC_W-1:0]          acc_ff, acc_in;
   logic [1:0]                       status_ff, status_in;
   logic signed [mps_pkg::SCORE_W-1:0] rsp_score_ff, rsp_score_in;
   logic                             rsp_lf_ff, rsp_lf_in, rsp_rf_ff, rsp_rf_in;
   logic [1:0]                       rsp_status_ff, rsp_status_in;

   // memory
   logic [ENT_W-1:0]                 mem [MAX_RECTS];
   logic [ENT_W-1:0]                 rd_data_ff;
   logic                             mem_we;
   logic                             rd_issue;

   // scan compare unit
   logic [CW-1:0]                    r_x, r_y, r_w, r_h;
   logic [CW:0]                      cen_r, cen_c;
   logic signed [CW+1:0]             cen_diff;
   logic [CW:0]                      cen_abs;
   logic [CW-1:0]                    half_max;
   logic                             overlap, left_hit, right_hit;
   logic [CW:0]                      x_plus_w, bin_c;

   // mode datapath
   logic [2*CW-1:0]                  prod;
   logic signed [CW:0]               d_w, d_h;
   logic signed [SAT_W-1:0]          acc_ext;

   function automatic logic [CW:0] cen_abs_neg(input logic signed [CW+1:0] v);
      logic signed [CW+1:0] n;
      n = -v;
      return n[CW:0];
   endfunction

   // compare one stored rectangle against the candidate
   always_comb begin
      r_x      = rd_data_ff[4*CW-1:3*CW];
      r_y      = rd_data_ff[3*CW-1:2*CW];
      r_w      = rd_data_ff[2*CW-1:CW];
      r_h      = rd_data_ff[CW-1:0];
      cen_r    = (CW+1)'(r_y) + (CW+1)'(r_h >> 1);
      cen_c    = (CW+1)'(y_ff) + (CW+1)'(h_ff >> 1);
      cen_diff = $signed({1'b0, cen_r}) - $signed({1'b0, cen_c});
      cen_abs  = cen_diff[CW+1] ? cen_abs_neg(cen_diff) : cen_diff[CW:0];
      half_max = ((r_h > h_ff) ? r_h : h_ff) >> 1;
      overlap  = cen_abs < (CW+1)'(half_max);
      x_plus_w = (CW+1)'(x_ff) + (CW+1)'(w_ff);
      left_hit  = overlap && (((CW+1)'(r_x) + (CW+1)'(r_w)) == (CW+1)'(x_ff));
      right_hit = overlap && ((CW+1)'(r_x) == x_plus_w);
      bin_c    = (CW+1)'(bin_width_ff[BW-1:0]);
   end

   // mode arithmetic and saturation
   always_comb begin
      prod    = w_ff * h_ff;
      d_w     = $signed({1'b0, w_ff}) - $signed({1'b0, iw_ff});
      d_h     = $signed({1'b0, h_ff}) - $signed({1'b0, ih_ff});
      acc_ext = SAT_W'(acc_ff);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mps_pkg::S_IDLE: begin
            if (start) state_in = mps_pkg::S_EXEC;
         end
         mps_pkg::S_EXEC: begin
            if (act_ff == mps_pkg::ACT_SCORE && mode_ff == mps_pkg::MODE_TOP_LEFT) begin
               state_in = (count_ff == '0) ? mps_pkg::S_BORDER : mps_pkg::S_SCAN;
            end else begin
               state_in = mps_pkg::S_RESP;
            end
         end
         mps_pkg::S_SCAN: begin
            if ((idx_ff + CNT_W'(1)) == count_ff) state_in = mps_pkg::S_DRAIN;
         end
         mps_pkg::S_DRAIN:  state_in = mps_pkg::S_BORDER;
         mps_pkg::S_BORDER: state_in = mps_pkg::S_RESP;
         mps_pkg::S_RESP:   state_in = mps_pkg::S_IDLE;
         default:           state_in = mps_pkg::S_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      busy          = (state_ff != mps_pkg::S_IDLE);
      count_in      = count_ff;
      idx_in        = idx_ff;
      rsp_valid_in  = 1'b0;
      mem_we        = 1'b0;
      rd_issue      = 1'b0;
      act_in        = act_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      w_in          = w_ff;
      h_in          = h_ff;
      iw_in         = iw_ff;
      ih_in         = ih_ff;
      lf_in         = lf_ff;
      rf_in         = rf_ff;
      acc_in        = acc_ff;
      status_in     = status_ff;
      rsp_score_in  = rsp_score_ff;
      rsp_lf_in     = rsp_lf_ff;
      rsp_rf_in     = rsp_rf_ff;
      rsp_status_in = rsp_status_ff;

      // accumulate the neighbour search on each word read back
      if (rd_vld_ff) begin
         if (left_hit) begin
            acc_in = acc_in - $signed(ACC_W'(mps_pkg::NEIGHBOR_BONUS));
            lf_in  = 1'b1;
         end
         if (right_hit) begin
            acc_in = acc_in - $signed(ACC_W'(mps_pkg::NEIGHBOR_BONUS));
            rf_in  = 1'b1;
         end
      end

      unique case (state_ff)
         mps_pkg::S_IDLE: begin
            // latch the request word
            if (start) begin
               act_in = req_action;
               x_in   = req_rect_x;
               y_in   = req_rect_y;
               w_in   = req_rect_w;
               h_in   = req_rect_h;
               iw_in  = req_image_w;
               ih_in  = req_image_h;
               lf_in  = req_left_in;
               rf_in  = req_right_in;
            end
         end
         mps_pkg::S_EXEC: begin
            acc_in    = '0;
            status_in = mps_pkg::ST_DONE;
            idx_in    = '0;
            unique case (act_ff)
               mps_pkg::ACT_CLEAR: begin
                  count_in = '0;
                  lf_in    = 1'b0;
                  rf_in    = 1'b0;
               end
               mps_pkg::ACT_APPEND: begin
                  lf_in = 1'b0;
                  rf_in = 1'b0;
                  if (count_ff < CNT_W'(MAX_RECTS)) begin
                     mem_we   = 1'b1;
                     count_in = count_ff + CNT_W'(1);
                  end else begin
                     status_in = mps_pkg::ST_FULL;
                  end
               end
               mps_pkg::ACT_SCORE: begin
                  status_in = mps_pkg::ST_SCORE_OK;
                  case (mode_ff)
                     mps_pkg::MODE_TOP_LEFT:   acc_in = $signed(ACC_W'(y_ff));
                     mps_pkg::MODE_AREA:       acc_in = $signed(ACC_W'(prod));
                     mps_pkg::MODE_SHORT_SIDE: acc_in = ACC_W'((d_w < d_h) ? d_w : d_h);
                     mps_pkg::MODE_LONG_SIDE:  acc_in = ACC_W'((d_w > d_h) ? d_w : d_h);
                     mps_pkg::MODE_MIN_WIDTH:  acc_in = $signed(ACC_W'(w_ff));
                     mps_pkg::MODE_MIN_HEIGHT: acc_in = $signed(ACC_W'(h_ff));
                     default:                  acc_in = '0;
                  endcase
               end
               default: begin
                  lf_in = 1'b0;
                  rf_in = 1'b0;
               end
            endcase
         end
         mps_pkg::S_SCAN: begin
            // issue one table read a cycle
            rd_issue = 1'b1;
            idx_in   = idx_ff + CNT_W'(1);
         end
         mps_pkg::S_DRAIN: begin
         end
         mps_pkg::S_BORDER: begin
            // bin borders count only when neither flag is set, by a neighbour or by the request
            if (!(lf_ff || rf_ff)) begin
               if (x_plus_w == bin_c) begin
                  acc_in = acc_in - $signed(ACC_W'(mps_pkg::BORDER_BONUS));
                  rf_in  = 1'b1;
               end
               if (x_ff == '0) begin
                  acc_in = acc_in - $signed(ACC_W'(mps_pkg::BORDER_BONUS));
                  lf_in  = 1'b1;
               end
            end
         end
         mps_pkg::S_RESP: begin
            // saturate and strobe the result word
            rsp_valid_in = 1'b1;
            if (acc_ext > SAT_W'(mps_pkg::SCORE_MAX)) begin
               rsp_score_in = mps_pkg::SCORE_W'(mps_pkg::SCORE_MAX);
            end else if (acc_ext < SAT_W'(mps_pkg::SCORE_MIN)) begin
               rsp_score_in = mps_pkg::SCORE_W'(mps_pkg::SCORE_MIN);
            end else begin
               rsp_score_in = acc_ext[mps_pkg::SCORE_W-1:0];
            end
            rsp_lf_in     = lf_ff;
            rsp_rf_in     = rf_ff;
            rsp_status_in = status_ff;
         end
         default: begin
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mps_pkg::S_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= '0;
         bin_width_ff <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         rd_vld_ff    <= rd_issue;
         rsp_valid_ff <= rsp_valid_in;
         // register writes
         if (csr_we) begin
            unique case (csr_addr)
               mps_pkg::REG_SCORE_MODE: mode_ff      <= csr_wdata[mps_pkg::MODE_W-1:0];
               mps_pkg::REG_BIN_WIDTH:  bin_width_ff <= csr_wdata[mps_pkg::BIN_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      act_ff        <= act_in;
      x_ff          <= x_in;
      y_ff          <= y_in;
      w_ff          <= w_in;
      h_ff          <= h_in;
      iw_ff         <= iw_in;
      ih_ff         <= ih_in;
      lf_ff         <= lf_in;
      rf_ff         <= rf_in;
      acc_ff        <= acc_in;
      status_ff     <= status_in;
      rsp_score_ff  <= rsp_score_in;
      rsp_lf_ff     <= rsp_lf_in;
      rsp_rf_ff     <= rsp_rf_in;
      rsp_status_ff <= rsp_status_in;
   end

   // rectangle table: append at the fill count
   always_ff @(posedge clock) begin
      if (mem_we) mem[count_ff[AW-1:0]] <= {x_ff, y_ff, w_ff, h_ff};
   end

   // rectangle table: registered read for the scan
   always_ff @(posedge clock) begin
      if (rd_issue) rd_data_ff <= mem[idx_ff[AW-1:0]];
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_score       = rsp_score_ff;
   assign rsp_left_found  = rsp_lf_ff;
   assign rsp_right_found = rsp_rf_ff;
   assign rsp_status      = rsp_status_ff;

endmodule

`default_nettype wire

### bench/tb_maxrects_placement_score.sv
`timescale 1ns / 1ps

// Self-checking bench for maxrects_placement_score: a checker class predicts
// every result word and compares it, plain tasks drive requests and registers.
// Depends on mps_pkg and maxrects_placement_score.

module tb_maxrects_placement_score;

   localparam int COORD_BITS   = 14;
   localparam int MAX_RECTS    = 256;
   localparam int WORD_TARGET  = 1350;
   localparam int PHASE_WORDS  = 70;
   localparam int STALL_LIMIT  = 4000;
   localparam int DRAIN_CYCLES = 20;

   // Codes outside the documented ranges that the block must still handle
   localparam logic [1:0] ACT_UNUSED  = 2'd3;
   localparam logic [2:0] MODE_UNUSED = 3'd7;

   typedef logic [COORD_BITS-1:0] coord_type;
   localparam coord_type COORD_MAX = '1;

   typedef struct packed {
      logic [1:0] action;
      coord_type  x;
      coord_type  y;
      coord_type  w;
      coord_type  h;
      coord_type  iw;
      coord_type  ih;
      logic       left_in;
      logic       right_in;
   } request_type;

   typedef struct packed {
      logic signed [mps_pkg::SCORE_W-1:0] score;
      logic                               left_found;
      logic                               right_found;
      logic [1:0]                         status;
   } result_type;

   // Shadow of the placed-rectangle table and registers, plus result checks
   class score_checker;
      coord_type  placed_x [MAX_RECTS];
      coord_type  placed_y [MAX_RECTS];
      coord_type  placed_w [MAX_RECTS];
      coord_type  placed_h [MAX_RECTS];
      int         placed_count;
      logic [2:0] mode;
      coord_type  bin_w;
      result_type expected_words [$];
      int         errors;
      int         scores;
      int         top_left_scores;
      int         neighbor_hits;
      int         dropped;
      int         ignored;

      function new();
         placed_count    = 0;
         mode            = mps_pkg::MODE_NONE;
         bin_w           = '0;
         errors          = 0;
         scores          = 0;
         top_left_scores = 0;
         neighbor_hits   = 0;
         dropped         = 0;
         ignored         = 0;
      endfunction

      function void configure(logic [2:0] new_mode, coord_type new_bin_w);
         mode  = new_mode;
         bin_w = new_bin_w;
      endfunction

      function int pending();
         return expected_words.size();
      endfunction

      // Walk the stored rectangles, then apply border bonuses if no flag is set
      function longint top_left_score(request_type r, inout bit lf, inout bit rf);
         longint cx, cy, cw, ch, sx, sy, sw, sh, center_gap, reach, m;
         int     k;
         cx = r.x;
         cy = r.y;
         cw = r.w;
         ch = r.h;
         m  = cy;
         for (k = 0; k < placed_count; k++) begin
            sx    = placed_x[k];
            sy    = placed_y[k];
            sw    = placed_w[k];
            sh    = placed_h[k];
            center_gap = (sy + sh / 2) - (cy + ch / 2);
            if (center_gap < 0) center_gap = -center_gap;
            reach = ((sh > ch) ? sh : ch) / 2;
            if (center_gap < reach) begin
               if (sx + sw == cx) begin
                  m -= mps_pkg::NEIGHBOR_BONUS;
                  lf = 1'b1;
                  neighbor_hits++;
               end
               if (sx == cx + cw) begin
                  m -= mps_pkg::NEIGHBOR_BONUS;
                  rf = 1'b1;
                  neighbor_hits++;
               end
            end
         end
         if (!(lf || rf)) begin
            if (cx + cw == longint'(bin_w)) begin
               m -= mps_pkg::BORDER_BONUS;
               rf = 1'b1;
            end
            if (cx == 0) begin
               m -= mps_pkg::BORDER_BONUS;
               lf = 1'b1;
            end
         end
         return m;
      endfunction

      // Update the shadow state for one accepted word and queue its result
      function void note_word(request_type r);
         result_type e;
         longint     sc, dw, dh;
         bit         lf, rf;
         e = '0;
         case (r.action)
            mps_pkg::ACT_CLEAR: placed_count = 0;
            mps_pkg::ACT_APPEND: begin
               if (placed_count < MAX_RECTS) begin
                  placed_x[placed_count] = r.x;
                  placed_y[placed_count] = r.y;
                  placed_w[placed_count] = r.w;
                  placed_h[placed_count] = r.h;
                  placed_count++;
               end else begin
                  e.status = mps_pkg::ST_FULL;
                  dropped++;
               end
            end
            mps_pkg::ACT_SCORE: begin
               lf = r.left_in;
               rf = r.right_in;
               dw = longint'(r.w) - longint'(r.iw);
               dh = longint'(r.h) - longint'(r.ih);
               scores++;
               case (mode)
                  mps_pkg::MODE_TOP_LEFT: begin
                     sc = top_left_score(r, lf, rf);
                     top_left_scores++;
                  end
                  mps_pkg::MODE_AREA:       sc = longint'(r.w) * longint'(r.h);
                  mps_pkg::MODE_SHORT_SIDE: sc = (dw < dh) ? dw : dh;
                  mps_pkg::MODE_LONG_SIDE:  sc = (dw > dh) ? dw : dh;
                  mps_pkg::MODE_MIN_WIDTH:  sc = r.w;
                  mps_pkg::MODE_MIN_HEIGHT: sc = r.h;
                  default:                  sc = 0;
               endcase
               if (sc > mps_pkg::SCORE_MAX) sc = mps_pkg::SCORE_MAX;
               if (sc < mps_pkg::SCORE_MIN) sc = mps_pkg::SCORE_MIN;
               e.score       = sc[mps_pkg::SCORE_W-1:0];
               e.left_found  = lf;
               e.right_found = rf;
               e.status      = mps_pkg::ST_SCORE_OK;
            end
            default: ignored++;
         endcase
         expected_words.push_back(e);
      endfunction

      // Compare one result word with the oldest prediction
      function void check_word(result_type got);
         result_type e;
         if (expected_words.size() == 0) begin
            $error("result word with nothing pending: status %0d score %0d",
                   got.status, $signed(got.score));
            errors++;
            return;
         end
         e = expected_words.pop_front();
         if (got.score !== e.score) begin
            $error("score: expected %0d, got %0d", $signed(e.score), $signed(got.score));
            errors++;
         end
         if (got.left_found !== e.left_found) begin
            $error("left_found: expected %0b, got %0b", e.left_found, got.left_found);
            errors++;
         end
         if (got.right_found !== e.right_found) begin
            $error("right_found: expected %0b, got %0b", e.right_found, got.right_found);
            errors++;
         end
         if (got.status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, got.status);
            errors++;
         end
      endfunction
   endclass

   logic                               clock = 1'b0;
   logic                               reset;
   logic                               start;
   logic                               busy;
   logic [1:0]                         req_action;
   coord_type                          req_rect_x;
   coord_type                          req_rect_y;
   coord_type                          req_rect_w;
   coord_type                          req_rect_h;
   coord_type                          req_image_w;
   coord_type                          req_image_h;
   logic                               req_left_in;
   logic                               req_right_in;
   logic                               rsp_valid;
   logic signed [mps_pkg::SCORE_W-1:0] rsp_score;
   logic                               rsp_left_found;
   logic                               rsp_right_found;
   logic [1:0]                         rsp_status;
   logic                               csr_we;
   logic [mps_pkg::CSR_ADDR_W-1:0]     csr_addr;
   logic [mps_pkg::CSR_DATA_W-1:0]     csr_wdata;

   score_checker score_chk;
   bit           word_held;
   bit           no_gaps;
   int           words_sent;
   int           settings;
   int           stall_cycles;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   maxrects_placement_score #(
      .MAX_RECTS  (MAX_RECTS),
      .COORD_BITS (COORD_BITS)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_action      (req_action),
      .req_rect_x      (req_rect_x),
      .req_rect_y      (req_rect_y),
      .req_rect_w      (req_rect_w),
      .req_rect_h      (req_rect_h),
      .req_image_w     (req_image_w),
      .req_image_h     (req_image_h),
      .req_left_in     (req_left_in),
      .req_right_in    (req_right_in),
      .rsp_valid       (rsp_valid),
      .rsp_score       (rsp_score),
      .rsp_left_found  (rsp_left_found),
      .rsp_right_found (rsp_right_found),
      .rsp_status      (rsp_status),
      .csr_we          (csr_we),
      .csr_addr        (csr_addr),
      .csr_wdata       (csr_wdata)
   );

   // Check result words, note accepted words, and end the run on a stall
   always @(posedge clock) begin : monitor
      result_type  got;
      request_type seen;
      if (reset) begin
         stall_cycles = 0;
      end else begin
         if (rsp_valid) begin
            got = '{rsp_score, rsp_left_found, rsp_right_found, rsp_status};
            score_chk.check_word(got);
         end
         if (start && !busy) begin
            seen = '{req_action, req_rect_x, req_rect_y, req_rect_w, req_rect_h,
                     req_image_w, req_image_h, req_left_in, req_right_in};
            score_chk.note_word(seen);
         end
         if (rsp_valid || (start && !busy)) stall_cycles = 0;
         else stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   function automatic request_type make_word(logic [1:0] act, coord_type x, coord_type y,
                                             coord_type w, coord_type h, coord_type iw,
                                             coord_type ih, logic l, logic r);
      return '{act, x, y, w, h, iw, ih, l, r};
   endfunction

   // Bias toward the ends of the range and toward a small working area
   function automatic coord_type rand_coord();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return COORD_MAX;
         2, 3:    return coord_type'($urandom_range(0, 16383));
         default: return coord_type'($urandom_range(0, 400));
      endcase
   endfunction

   function automatic request_type random_word();
      request_type wd;
      wd.action   = ($urandom_range(0, 7) == 0) ? ACT_UNUSED : 2'($urandom_range(0, 2));
      wd.x        = rand_coord();
      wd.y        = rand_coord();
      wd.w        = rand_coord();
      wd.h        = rand_coord();
      wd.iw       = rand_coord();
      wd.ih       = rand_coord();
      wd.left_in  = 1'($urandom_range(0, 1));
      wd.right_in = 1'($urandom_range(0, 1));
      return wd;
   endfunction

   // Present one word after a random gap (none when no_gaps is set); return once busy is low
   task automatic send_word(input request_type wd);
      int unsigned gap;
      gap = no_gaps ? 0 : $urandom_range(0, 5);
      if (gap != 0 && word_held) begin
         start     <= 1'b0;
         word_held = 1'b0;
      end
      repeat (gap) @(posedge clock);
      start        <= 1'b1;
      req_action   <= wd.action;
      req_rect_x   <= wd.x;
      req_rect_y   <= wd.y;
      req_rect_w   <= wd.w;
      req_rect_h   <= wd.h;
      req_image_w  <= wd.iw;
      req_image_h  <= wd.ih;
      req_left_in  <= wd.left_in;
      req_right_in <= wd.right_in;
      word_held    = 1'b1;
      if (wd.action != ACT_UNUSED) words_sent++;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // Drop start and wait until every predicted result word has come back
   task automatic settle();
      if (word_held) begin
         start     <= 1'b0;
         word_held = 1'b0;
      end
      do @(posedge clock); while (score_chk.pending() != 0);
   endtask

   // Write both registers on consecutive edges; call only while idle
   task automatic program_csr(input logic [2:0] mode, input coord_type binw);
      csr_we    <= 1'b1;
      csr_addr  <= mps_pkg::REG_SCORE_MODE;
      csr_wdata <= mps_pkg::CSR_DATA_W'(mode);
      @(posedge clock);
      csr_addr  <= mps_pkg::REG_BIN_WIDTH;
      csr_wdata <= binw;
      @(posedge clock);
      csr_we    <= 1'b0;
      score_chk.configure(mode, binw);
      settings++;
   endtask

   // Clear, place rectangles around one candidate, then score it
   task automatic run_layout(input int n_rects, input int n_scores);
      coord_type   cx, cy, cw, ch, rx, ry, rw, rh;
      request_type wd;
      int          i;
      no_gaps = ($urandom_range(0, 4) == 0);
      cw = coord_type'($urandom_range(0, 60));
      ch = coord_type'($urandom_range(0, 60));
      case ($urandom_range(0, 3))
         0:       cx = '0;
         1:       cx = (score_chk.bin_w >= cw) ? score_chk.bin_w - cw : rand_coord();
         2:       cx = rand_coord();
         default: cx = coord_type'($urandom_range(0, 400));
      endcase
      cy = ($urandom_range(0, 3) == 0) ? rand_coord() : coord_type'($urandom_range(0, 400));
      wd = random_word();
      wd.action = mps_pkg::ACT_CLEAR;
      send_word(wd);
      for (i = 0; i < n_rects; i++) begin
         // keep long fills intact, sprinkle noise into short layouts
         if (n_rects <= 32 && $urandom_range(0, 15) == 0) send_word(random_word());
         rw = coord_type'($urandom_range(1, 60));
         rh = coord_type'($urandom_range(0, 80));
         ry = cy + coord_type'($urandom_range(0, 80)) - coord_type'(40);
         case ($urandom_range(0, 3))
            0:       rx = (cx >= rw) ? cx - rw : '0;
            1:       rx = cx + cw;
            default: rx = cx + coord_type'($urandom_range(0, 120)) - coord_type'(60);
         endcase
         wd = random_word();
         wd.action = mps_pkg::ACT_APPEND;
         wd.x = rx;
         wd.y = ry;
         wd.w = rw;
         wd.h = rh;
         send_word(wd);
      end
      for (i = 0; i < n_scores; i++) begin
         wd = random_word();
         wd.action = mps_pkg::ACT_SCORE;
         wd.x = cx;
         wd.y = cy;
         wd.w = cw;
         wd.h = ch;
         if ($urandom_range(0, 3) == 0)
            wd.x = cx + coord_type'($urandom_range(0, 2)) - coord_type'(1);
         wd.left_in  = ($urandom_range(0, 3) == 0);
         wd.right_in = ($urandom_range(0, 3) == 0);
         send_word(wd);
      end
   endtask

   initial begin : stimulus
      request_type wd;
      logic [2:0]  mode;
      coord_type   binw;
      int          di;
      int          phase;
      int          phase_base;
      score_chk    = new();
      word_held    = 1'b0;
      no_gaps      = 1'b0;
      words_sent   = 0;
      settings     = 0;
      stall_cycles = 0;
      reset        <= 1'b1;
      start        <= 1'b0;
      req_action   <= mps_pkg::ACT_CLEAR;
      req_rect_x   <= '0;
      req_rect_y   <= '0;
      req_rect_w   <= '0;
      req_rect_h   <= '0;
      req_image_w  <= '0;
      req_image_h  <= '0;
      req_left_in  <= 1'b0;
      req_right_in <= 1'b0;
      csr_we       <= 1'b0;
      csr_addr     <= mps_pkg::REG_SCORE_MODE;
      csr_wdata    <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Registers at reset: scoring off, flags pass, unused action, extremes
      send_word(make_word(mps_pkg::ACT_SCORE, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                          COORD_MAX, COORD_MAX, 1'b1, 1'b0));
      send_word(make_word(ACT_UNUSED, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                          COORD_MAX, COORD_MAX, 1'b1, 1'b1));
      send_word(make_word(mps_pkg::ACT_APPEND, '0, '0, '0, '0, '0, '0, 1'b0, 1'b0));
      send_word(make_word(mps_pkg::ACT_APPEND, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                          COORD_MAX, COORD_MAX, 1'b1, 1'b1));
      send_word(make_word(mps_pkg::ACT_CLEAR, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                          COORD_MAX, COORD_MAX, 1'b1, 1'b1));

      // Top-left: neighbors on both sides, overlap at the limit, border bonus
      settle();
      program_csr(mps_pkg::MODE_TOP_LEFT, coord_type'(100));
      send_word(make_word(mps_pkg::ACT_CLEAR, '0, '0, '0, '0, '0, '0, 1'b0, 1'b0));
      send_word(make_word(mps_pkg::ACT_APPEND, 10, 20, 30, 40, 0, 0, 1'b0, 1'b0));
      send_word(make_word(mps_pkg::ACT_APPEND, 60, 20, 5, 40, 0, 0, 1'b0, 1'b0));
      send_word(make_word(mps_pkg::ACT_APPEND, 0, 40, 40, 40, 0, 0, 1'b0, 1'b0));
      send_word(make_word(mps_pkg::ACT_APPEND, 60, 39, 8, 40, 0, 0, 1'b0, 1'b0));
      send_word(make_word(mps_pkg::ACT_SCORE, 40, 20, 20, 40, 7, 9, 1'b0, 1'b0));
      send_word(make_word(mps_pkg::ACT_SCORE, 40, 20, 20, 40, 7, 9, 1'b1, 1'b1));
      send_word(make_word(mps_pkg::ACT_SCORE, 0, 5000, 100, 3, 0, 0, 1'b0, 1'b0));
      send_word(make_word(mps_pkg::ACT_SCORE, 0, 5000, 100, 3, 0, 0, 1'b1, 1'b0));
      send_word(make_word(mps_pkg::ACT_SCORE, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                          COORD_MAX, COORD_MAX, 1'b0, 1'b0));
      send_word(make_word(mps_pkg::ACT_CLEAR, '0, '0, '0, '0, '0, '0, 1'b0, 1'b0));
      send_word(make_word(mps_pkg::ACT_SCORE, '0, '0, '0, '0, '0, '0, 1'b0, 1'b0));

      // One extreme word per remaining mode, the unused mode last
      for (di = 0; di < 6; di++) begin
         binw = (di % 2 == 0) ? COORD_MAX : '0;
         case (di)
            0: begin
               mode = mps_pkg::MODE_AREA;
               wd = make_word(mps_pkg::ACT_SCORE, 0, 0, COORD_MAX, COORD_MAX, 0, 0,
                              1'b0, 1'b1);
            end
            1: begin
               mode = mps_pkg::MODE_SHORT_SIDE;
               wd = make_word(mps_pkg::ACT_SCORE, 0, 0, 0, 0, COORD_MAX, COORD_MAX,
                              1'b1, 1'b0);
            end
            2: begin
               mode = mps_pkg::MODE_LONG_SIDE;
               wd = make_word(mps_pkg::ACT_SCORE, 0, 0, COORD_MAX, 0, 0, COORD_MAX,
                              1'b0, 1'b0);
            end
            3: begin
               mode = mps_pkg::MODE_MIN_WIDTH;
               wd = make_word(mps_pkg::ACT_SCORE, 5, 5, COORD_MAX, 0, 0, 0, 1'b1, 1'b1);
            end
            4: begin
               mode = mps_pkg::MODE_MIN_HEIGHT;
               wd = make_word(mps_pkg::ACT_SCORE, 5, 5, 0, COORD_MAX, 0, 0, 1'b0, 1'b0);
            end
            default: begin
               mode = MODE_UNUSED;
               wd = make_word(mps_pkg::ACT_SCORE, COORD_MAX, COORD_MAX, COORD_MAX,
                              COORD_MAX, COORD_MAX, COORD_MAX, 1'b1, 1'b1);
            end
         endcase
         settle();
         program_csr(mode, binw);
         send_word(wd);
      end

      // Random phases: top-left every other phase, two of them fill the table
      phase = 0;
      while (words_sent < WORD_TARGET) begin
         if (phase % 2 == 0) begin
            mode = mps_pkg::MODE_TOP_LEFT;
         end else begin
            case ((phase / 2) % 7)
               0:       mode = mps_pkg::MODE_AREA;
               1:       mode = mps_pkg::MODE_SHORT_SIDE;
               2:       mode = mps_pkg::MODE_LONG_SIDE;
               3:       mode = mps_pkg::MODE_MIN_WIDTH;
               4:       mode = mps_pkg::MODE_MIN_HEIGHT;
               5:       mode = mps_pkg::MODE_NONE;
               default: mode = MODE_UNUSED;
            endcase
         end
         if (phase == 0) begin
            binw = COORD_MAX;
         end else if (phase == 1) begin
            binw = '0;
         end else begin
            case ($urandom_range(0, 3))
               0:       binw = '0;
               1:       binw = COORD_MAX;
               2:       binw = coord_type'($urandom_range(0, 16383));
               default: binw = coord_type'($urandom_range(100, 500));
            endcase
         end
         settle();
         program_csr(mode, binw);
         phase_base = words_sent;
         if (phase == 2 || phase == 5) run_layout(MAX_RECTS + $urandom_range(1, 3), 3);
         while (words_sent - phase_base < PHASE_WORDS)
            run_layout($urandom_range(0, 12), $urandom_range(1, 6));
         phase++;
      end

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d request words over %0d register settings",
               words_sent, settings);
      $display("%0d scores (%0d top-left), %0d neighbor contacts, %0d dropped appends, %0d unused",
               score_chk.scores, score_chk.top_left_scores, score_chk.neighbor_hits,
               score_chk.dropped, score_chk.ignored);
      if (score_chk.errors == 0 && score_chk.pending() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
